### src/tmscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Template macro scanner package
// Character classes, event codes, character constants and the result word
// shared by the scanner.
// ----------------------------------------------------------------------------
package tmscan_pkg;

    localparam int CHAR_BITS  = 8;
    localparam int EVENT_BITS = 3;
    localparam int OUT_POS_BITS = 16;

    localparam logic [CHAR_BITS-1:0] CHAR_LBRACE = 8'h7B; // '{'
    localparam logic [CHAR_BITS-1:0] CHAR_RBRACE = 8'h7D; // '}'
    localparam logic [CHAR_BITS-1:0] CHAR_DOLLAR = 8'h24; // '$'
    localparam logic [CHAR_BITS-1:0] CHAR_LPAR   = 8'h28; // '('
    localparam logic [CHAR_BITS-1:0] CHAR_RPAR   = 8'h29; // ')'
    localparam logic [CHAR_BITS-1:0] CHAR_COMMA  = 8'h2C; // ','
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = 8'h2D; // '-'

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE   = 3'd0,
        EV_NAME   = 3'd1,
        EV_PARAM  = 3'd2,
        EV_PEND   = 3'd3,
        EV_FOUND  = 3'd4,
        EV_NOMORE = 3'd5
    } event_kind_t;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_ALPHA,
        CL_DIGIT,
        CL_MINUS,
        CL_COMMA,
        CL_LPAR,
        CL_RPAR,
        CL_LBRACE,
        CL_RBRACE,
        CL_DOLLAR
    } char_class_t;

    // One result word as it waits in the output or skid register.
    typedef struct packed {
        event_kind_t                kind;
        logic [CHAR_BITS-1:0]       char_val;
        logic [OUT_POS_BITS-1:0]    start_pos;
        logic [OUT_POS_BITS-1:0]    end_pos;
    } result_t;

    function automatic char_class_t classify(input logic [CHAR_BITS-1:0] c);
        char_class_t cl;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            cl = CL_ALPHA;
        else if (c >= 8'h30 && c <= 8'h39)
            cl = CL_DIGIT;
        else if (c == CHAR_COMMA)
            cl = CL_COMMA;
        else if (c == CHAR_MINUS)
            cl = CL_MINUS;
        else if (c == CHAR_LPAR)
            cl = CL_LPAR;
        else if (c == CHAR_RPAR)
            cl = CL_RPAR;
        else if (c == CHAR_LBRACE)
            cl = CL_LBRACE;
        else if (c == CHAR_RBRACE)
            cl = CL_RBRACE;
        else if (c == CHAR_DOLLAR)
            cl = CL_DOLLAR;
        else
            cl = CL_OTHER;
        return cl;
    endfunction

endpackage

### src/template_macro_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Template macro scanner
// Finds {$name} and {$name(p1,p2,...)} macros in a streamed text and gives
// one event word for every character of the text.
// ----------------------------------------------------------------------------
//
// Usage:
//   The text channel (text_valid / text_stall) carries one character per
//   word, with text_last set on the final character of a text. The event
//   channel (event_valid / event_stall) returns exactly one event word for
//   every character accepted, in order.
//   Each event is registered in the output register, or in the skid
//   register while the receiver stalls. Throughput is one character per
//   cycle while the receiver does not stall; the classifier and the scan
//   state step lie between text port and output register; nothing iterates.
//   When the receiver stalls, the waiting event stays in the output register
//   and one further character is still taken into a skid register; only
//   then is text_stall raised, and it drops once the receiver moves again.
//   Reset clears the scan state, the position counters and both valid
//   flags, so no event is presented after reset. After the last character
//   of a text the scan state and positions return to their reset values.
//   Positions count from zero at the first character and saturate at the
//   top of the POS_BITS counter; the low 16 bits are reported.
//
module template_macro_scanner #(
    parameter int POS_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  text_valid,
    output logic                                  text_stall,
    input  logic [tmscan_pkg::CHAR_BITS-1:0]      text_char,
    input  logic                                  text_last,

    output logic                                  event_valid,
    input  logic                                  event_stall,
    output logic [tmscan_pkg::EVENT_BITS-1:0]     event_kind,
    output logic [tmscan_pkg::CHAR_BITS-1:0]      char_out,
    output logic [tmscan_pkg::OUT_POS_BITS-1:0]   macro_start_pos,
    output logic [tmscan_pkg::OUT_POS_BITS-1:0]   macro_end_pos
);

    import tmscan_pkg::*;

    // Scan states: outside a macro, just after '{', in the name, in the
    // parameter list, and after the closing ')'.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_BRACE = 3'd1,
        ST_NAME  = 3'd2,
        ST_PARAM = 3'd3,
        ST_CLOSE = 3'd4
    } scan_state_t;

    scan_state_t          state_reg, state_next;
    logic [POS_BITS-1:0]  text_position_reg, text_position_next;
    logic [POS_BITS-1:0]  brace_position_reg, brace_position_next;

    result_t              out_reg, skid_reg, result_next;
    logic                 out_valid_reg, skid_valid_reg;

    logic                 accept;
    logic                 out_take;
    char_class_t          cl;
    logic [31:0]          brace_pos_wide;
    logic [31:0]          text_pos_wide;

    assign accept   = text_valid && !text_stall;
    assign out_take = out_valid_reg && !event_stall;
    assign cl       = classify(text_char);

    // The skid register is the only thing that can hold the text side back.
    assign text_stall = skid_valid_reg;

    assign brace_pos_wide = 32'(brace_position_reg);
    assign text_pos_wide  = 32'(text_position_reg);

    // Scan state step and event for the character at the text port.
    always_comb
    begin
        state_next          = state_reg;
        brace_position_next = brace_position_reg;
        result_next.kind      = EV_NONE;
        result_next.char_val  = '0;
        result_next.start_pos = '0;
        result_next.end_pos   = '0;

        unique case (state_reg)
            ST_BRACE:
            begin
                // A brace not followed directly by '$' is dropped.
                state_next = (cl == CL_DOLLAR) ? ST_NAME : ST_IDLE;
            end
            ST_NAME:
            begin
                if (cl == CL_ALPHA || cl == CL_DIGIT || cl == CL_MINUS ||
                    cl == CL_OTHER)
                begin
                    result_next.kind     = EV_NAME;
                    result_next.char_val = text_char;
                end
                else if (cl == CL_LPAR)
                begin
                    state_next = ST_PARAM;
                end
                else if (cl == CL_RBRACE)
                begin
                    result_next.kind      = EV_FOUND;
                    result_next.start_pos = brace_pos_wide[OUT_POS_BITS-1:0];
                    result_next.end_pos   = text_pos_wide[OUT_POS_BITS-1:0];
                    state_next            = ST_IDLE;
                end
            end
            ST_PARAM:
            begin
                if (cl == CL_ALPHA || cl == CL_DIGIT || cl == CL_MINUS)
                begin
                    result_next.kind     = EV_PARAM;
                    result_next.char_val = text_char;
                end
                else if (cl == CL_COMMA)
                begin
                    result_next.kind = EV_PEND;
                end
                else if (cl == CL_RPAR)
                begin
                    result_next.kind = EV_PEND;
                    state_next       = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                if (cl == CL_RBRACE)
                begin
                    result_next.kind      = EV_FOUND;
                    result_next.start_pos = brace_pos_wide[OUT_POS_BITS-1:0];
                    result_next.end_pos   = text_pos_wide[OUT_POS_BITS-1:0];
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                if (cl == CL_LBRACE)
                begin
                    brace_position_next = text_position_reg;
                    state_next          = ST_BRACE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        // Saturating position counter.
        if (text_position_reg != {POS_BITS{1'b1}})
            text_position_next = text_position_reg + POS_BITS'(1);
        else
            text_position_next = text_position_reg;

        // The last character ends the text: unless it completes a macro it
        // reports that no further macro follows, and all state goes back.
        if (text_last)
        begin
            if (result_next.kind != EV_FOUND)
            begin
                result_next.kind      = EV_NOMORE;
                result_next.char_val  = '0;
                result_next.start_pos = '0;
                result_next.end_pos   = '0;
            end
            state_next          = ST_IDLE;
            text_position_next  = '0;
            brace_position_next = '0;
        end
    end

    // Scan state and control of the output and skid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            text_position_reg  <= '0;
            brace_position_reg <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg          <= state_next;
                text_position_reg  <= text_position_next;
                brace_position_reg <= brace_position_next;
            end

            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers follow the same routing and need no reset.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result_next;
        end
        else if (accept)
        begin
            skid_reg <= result_next;
        end
    end

    assign event_valid     = out_valid_reg;
    assign event_kind      = out_reg.kind;
    assign char_out        = out_reg.char_val;
    assign macro_start_pos = out_reg.start_pos;
    assign macro_end_pos   = out_reg.end_pos;

    // The skid register only fills behind a waiting output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word with no word in the output register");

    // A text always ends with the scanner back outside any macro at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_last) |=> (state_reg == ST_IDLE && text_position_reg == '0 &&
                                   brace_position_reg == '0))
        else $error("scan state not cleared after the last character");

    // Positions are only reported with a found macro.
    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind != EV_FOUND) |->
            (macro_start_pos == '0 && macro_end_pos == '0))
        else $error("macro positions reported without a found macro");

    // A character is only reported with name or parameter events.
    assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && event_kind != EV_NAME && event_kind != EV_PARAM) |->
            (char_out == '0))
        else $error("character reported with an event that carries none");

endmodule
